FILE: hdl/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg: shared types and constants for the swerve module kinematics unit
// Widths of the datapath, controller command and status types, the state
// encoding and the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package skm_pkg;

	localparam int XY_W      = 30;   // CORDIC x and y
	localparam int Z_W       = 34;   // CORDIC angle accumulator
	localparam int A_W       = 19;   // rotated strafe and corner sums
	localparam int SP_W      = 18;   // wheel speed before normalizing
	localparam int RAD_W     = 38;   // radicand of the square root
	localparam int PRD_W     = XY_W + A_W;
	localparam int CNT_W     = 6;
	localparam int SQRT_ITER = (RAD_W - 2) / 2 + 1;
	localparam int DIV_W     = 32;   // dividend bits, one quotient bit per step
	localparam int TABLE_LEN = 24;
	localparam logic [16:0] INV_GAIN = 17'd39796;
	localparam logic [SP_W-1:0] ONE_Q14 = SP_W'(16384);
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	typedef enum logic [4:0] {
		OP_NOP, OP_CAPTURE, OP_ROT_LOAD, OP_CSTEP, OP_MUL_X, OP_MUL_Y, OP_SUMS,
		OP_SQ1, OP_SQ2, OP_SQ3, OP_SQRT, OP_SQRT_DONE, OP_VLOAD, OP_VDONE,
		OP_MAX, OP_DLOAD, OP_DSTEP, OP_DDONE, OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] idx;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic zero_cmd;
		logic need_norm;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_ROT_LOAD, S_ROT_STEP, S_MUL_X, S_MUL_Y, S_SUMS, S_SQ1, S_SQ2,
		S_SQ3, S_SQRT, S_SQRT_DONE, S_VLOAD, S_VSTEP, S_VDONE, S_MAX, S_NORM,
		S_DLOAD, S_DSTEP, S_DDONE, S_OUT
	} state_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h2000_0000;
			5'd1:    v = 32'h12E4_051D;
			5'd2:    v = 32'h09FB_385B;
			5'd3:    v = 32'h0511_11D4;
			5'd4:    v = 32'h028B_0D43;
			5'd5:    v = 32'h0145_D7E1;
			5'd6:    v = 32'h00A2_F61E;
			5'd7:    v = 32'h0051_7C55;
			5'd8:    v = 32'h0028_BE53;
			5'd9:    v = 32'h0014_5F2E;
			5'd10:   v = 32'h000A_2F98;
			5'd11:   v = 32'h0005_17CC;
			5'd12:   v = 32'h0002_8BE6;
			5'd13:   v = 32'h0001_45F3;
			5'd14:   v = 32'h0000_A2F9;
			5'd15:   v = 32'h0000_517C;
			5'd16:   v = 32'h0000_28BE;
			5'd17:   v = 32'h0000_145F;
			5'd18:   v = 32'h0000_0A2F;
			5'd19:   v = 32'h0000_0517;
			5'd20:   v = 32'h0000_028B;
			5'd21:   v = 32'h0000_0145;
			5'd22:   v = 32'h0000_00A2;
			5'd23:   v = 32'h0000_0051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/skm_cordic.sv
// ----------------------------------------------------------------------------
// skm_cordic: shared CORDIC iteration unit
// One micro-rotation per step, in rotation mode (steered by the angle) or in
// vectoring mode (steered by the sign of y).
// ----------------------------------------------------------------------------
module skm_cordic import skm_pkg::*; (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    step,
	input  logic                    rot_mode,
	input  logic [4:0]              idx,
	input  logic signed [XY_W-1:0]  x0,
	input  logic signed [XY_W-1:0]  y0,
	input  logic signed [Z_W-1:0]   z0,
	output logic signed [XY_W-1:0]  x,
	output logic signed [XY_W-1:0]  y,
	output logic signed [Z_W-1:0]   z
);

	logic signed [XY_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]  z_q, at;
	logic                   pos;

	always_comb begin
		dx  = y_q >>> idx;
		dy  = x_q >>> idx;
		at  = signed'({{(Z_W-32){1'b0}}, atan_turn(idx)});
		pos = rot_mode ? ~z_q[Z_W-1] : y_q[XY_W-1];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (step) begin
			if (pos) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;

endmodule

FILE: hdl/skm_datapath.sv
// ----------------------------------------------------------------------------
// skm_datapath: arithmetic of the kinematics unit
// Yaw rotation and steering angles on a shared CORDIC, one shared multiplier,
// a bit-serial square root, a restoring divider and the held steering angles.
// ----------------------------------------------------------------------------
module skm_datapath import skm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [63:0]        in_data,
	output logic [14:0]        front_right_speed,
	output logic [14:0]        front_left_speed,
	output logic [14:0]        rear_right_speed,
	output logic [14:0]        rear_left_speed,
	output logic signed [15:0] front_right_steer,
	output logic signed [15:0] front_left_steer,
	output logic signed [15:0] rear_right_steer,
	output logic signed [15:0] rear_left_steer
);

	logic signed [15:0]      sx_q, sy_q, tr_q;
	logic [15:0]             hd_q;
	logic signed [A_W-1:0]   nx_q, a_q, b_q, c_q, d_q, tr_e, rnd, first, second;
	logic signed [PRD_W-1:0] p_q, rsum;
	logic signed [XY_W-1:0]  mul_a, cx, cy, c_x0, c_y0, rx, ry, vx, vy;
	logic signed [A_W-1:0]   mul_b;
	logic signed [Z_W-1:0]   cz, c_z0, rz, vz;
	logic [31:0]             ang, ang_f, zs;
	logic                    fold, vneg, rot_q, vzero_q;
	logic [RAD_W-1:0]        acc_q, rad_q, root_q, bit_q, trial_sq;
	logic [SP_W-1:0]         sp_q [4];
	logic [SP_W-1:0]         m_q, mx01, mx23;
	logic [DIV_W-1:0]        num_q;
	logic [SP_W-1:0]         rem_q;
	logic [SP_W:0]           trial_dv;
	logic [3:0][15:0]        held_q;
	logic [15:0]             steer, rr;
	logic [14:0]             osp_q [4];
	logic [3:0][15:0]        ost_q;

	skm_cordic u_cordic (
		.clk      (clk),
		.load     (cmd.op == OP_ROT_LOAD || cmd.op == OP_VLOAD),
		.step     (cmd.op == OP_CSTEP),
		.rot_mode (rot_q),
		.idx      (cmd.idx),
		.x0       (c_x0),
		.y0       (c_y0),
		.z0       (c_z0),
		.x        (cx),
		.y        (cy),
		.z        (cz)
	);

	always_comb begin
		// Yaw rotation setup: fold the angle into the right half plane.
		ang   = 32'h0 - {hd_q, 16'h0};
		fold  = (ang > QUARTER_TURN) && (ang < (32'h0 - QUARTER_TURN));
		ang_f = fold ? ang - HALF_TURN : ang;
		rx    = fold ? -XY_W'(sx_q) : XY_W'(sx_q);
		ry    = fold ? -XY_W'(sy_q) : XY_W'(sy_q);
		rz    = signed'({{(Z_W-32){ang_f[31]}}, ang_f});

		// Module pairs: front right (b,c), front left (b,d), rear right (a,c),
		// rear left (a,d). The angle is that of the vector (second, first).
		first  = cmd.sel[1] ? a_q : b_q;
		second = cmd.sel[0] ? d_q : c_q;
		vneg   = second[A_W-1];
		vx     = vneg ? -XY_W'(second) : XY_W'(second);
		vy     = vneg ? -XY_W'(first) : XY_W'(first);
		vz     = vneg ? signed'({{(Z_W-32){1'b0}}, HALF_TURN}) : '0;

		if (cmd.op == OP_ROT_LOAD) begin
			c_x0 = rx <<< 8;
			c_y0 = ry <<< 8;
			c_z0 = rz;
		end else begin
			c_x0 = vx <<< 8;
			c_y0 = vy <<< 8;
			c_z0 = vz;
		end

		case (cmd.op)
			OP_MUL_X: begin
				mul_a = cx;
				mul_b = signed'(A_W'(INV_GAIN));
			end
			OP_MUL_Y: begin
				mul_a = cy;
				mul_b = signed'(A_W'(INV_GAIN));
			end
			OP_SQ1: begin
				mul_a = XY_W'(first);
				mul_b = first;
			end
			default: begin
				mul_a = XY_W'(second);
				mul_b = second;
			end
		endcase

		rsum = p_q + signed'(PRD_W'(32'h0080_0000));
		rnd  = rsum[24+A_W-1:24];
		tr_e = A_W'(tr_q);

		trial_sq = root_q + bit_q;
		trial_dv = {rem_q, num_q[DIV_W-1]};

		mx01 = (sp_q[1] > sp_q[0]) ? sp_q[1] : sp_q[0];
		mx23 = (sp_q[3] > sp_q[2]) ? sp_q[3] : sp_q[2];

		zs    = cz[31:0] + 32'h0000_8000;
		rr    = zs[31:16];
		steer = vzero_q ? 16'h0 : 16'h0 - rr;

		stat.zero_cmd  = (sx_q == 16'sd0) && (sy_q == 16'sd0) && (tr_q == 16'sd0);
		stat.need_norm = m_q > ONE_Q14;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				sx_q <= in_data[15:0];
				sy_q <= in_data[31:16];
				tr_q <= in_data[47:32];
				hd_q <= in_data[63:48];
			end
			OP_ROT_LOAD: rot_q <= 1'b1;
			OP_VLOAD: begin
				rot_q   <= 1'b0;
				vzero_q <= (first == '0) && (second == '0);
			end
			OP_MUL_X: p_q <= mul_a * mul_b;
			OP_MUL_Y: begin
				nx_q <= rnd;
				p_q  <= mul_a * mul_b;
			end
			OP_SUMS: begin
				a_q <= nx_q - tr_e;
				b_q <= nx_q + tr_e;
				c_q <= rnd - tr_e;
				d_q <= rnd + tr_e;
			end
			OP_SQ1: p_q <= mul_a * mul_b;
			OP_SQ2: begin
				acc_q <= p_q[RAD_W-1:0];
				p_q   <= mul_a * mul_b;
			end
			OP_SQ3: begin
				rad_q  <= acc_q + p_q[RAD_W-1:0];
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end
			OP_SQRT: begin
				if (rad_q >= trial_sq) begin
					rad_q  <= rad_q - trial_sq;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_SQRT_DONE: sp_q[cmd.sel] <= root_q[SP_W-1:0];
			OP_MAX: m_q <= (mx23 > mx01) ? mx23 : mx01;
			OP_DLOAD: begin
				num_q <= {sp_q[cmd.sel], 14'h0} + DIV_W'(m_q >> 1);
				rem_q <= '0;
			end
			OP_DSTEP: begin
				if (trial_dv >= {1'b0, m_q}) begin
					rem_q <= SP_W'(trial_dv - {1'b0, m_q});
					num_q <= {num_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= trial_dv[SP_W-1:0];
					num_q <= {num_q[DIV_W-2:0], 1'b0};
				end
			end
			OP_DDONE: sp_q[cmd.sel] <= num_q[SP_W-1:0];
			OP_OUT: begin
				for (int i = 0; i < 4; i++) begin
					osp_q[i] <= sp_q[i][14:0];
				end
				ost_q <= held_q;
			end
			default: ;
		endcase
	end

	// Steering angles are only replaced when some command is nonzero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.op == OP_VDONE && !stat.zero_cmd) begin
			held_q[cmd.sel] <= steer;
		end
	end

	assign front_right_speed = osp_q[0];
	assign front_left_speed  = osp_q[1];
	assign rear_right_speed  = osp_q[2];
	assign rear_left_speed   = osp_q[3];
	assign front_right_steer = ost_q[0];
	assign front_left_steer  = ost_q[1];
	assign rear_right_steer  = ost_q[2];
	assign rear_left_steer   = ost_q[3];

`ifndef SYNTH
	a_speed_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |=> (osp_q[0] <= 15'd16384 && osp_q[1] <= 15'd16384 &&
		osp_q[2] <= 15'd16384 && osp_q[3] <= 15'd16384))
		else $error("wheel speed above 1.0 after normalizing");
	a_hold_steer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_VDONE && stat.zero_cmd) |=> $stable(held_q))
		else $error("steering angles changed on an all-zero command");
`endif

endmodule

FILE: hdl/skm_ctrl.sv
// ----------------------------------------------------------------------------
// skm_ctrl: sequencer of the kinematics unit
// Steps the datapath through rotation, corner sums, per-module magnitude and
// angle, and the optional normalizing divide; owns the stream handshakes.
// ----------------------------------------------------------------------------
module skm_ctrl import skm_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	output logic  m_axis_tvalid,
	input  logic  m_axis_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam int N_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(N_STEPS - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_ITER - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       sel_q;
	logic             out_valid_q, out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (s_axis_tvalid) state_d = S_ROT_LOAD;
			S_ROT_LOAD:  state_d = S_ROT_STEP;
			S_ROT_STEP:  if (cnt_q == ROT_LAST) state_d = S_MUL_X;
			S_MUL_X:     state_d = S_MUL_Y;
			S_MUL_Y:     state_d = S_SUMS;
			S_SUMS:      state_d = S_SQ1;
			S_SQ1:       state_d = S_SQ2;
			S_SQ2:       state_d = S_SQ3;
			S_SQ3:       state_d = S_SQRT;
			S_SQRT:      if (cnt_q == SQRT_LAST) state_d = S_SQRT_DONE;
			S_SQRT_DONE: state_d = S_VLOAD;
			S_VLOAD:     state_d = S_VSTEP;
			S_VSTEP:     if (cnt_q == ROT_LAST) state_d = S_VDONE;
			S_VDONE:     state_d = (sel_q == 2'd3) ? S_MAX : S_SQ1;
			S_MAX:       state_d = S_NORM;
			S_NORM:      state_d = stat.need_norm ? S_DLOAD : S_OUT;
			S_DLOAD:     state_d = S_DSTEP;
			S_DSTEP:     if (cnt_q == DIV_LAST) state_d = S_DDONE;
			S_DDONE:     state_d = (sel_q == 2'd3) ? S_OUT : S_DLOAD;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op  = OP_NOP;
		cmd.idx = cnt_q[4:0];
		cmd.sel = sel_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) cmd.op = OP_CAPTURE;
			end
			S_ROT_LOAD:  cmd.op = OP_ROT_LOAD;
			S_ROT_STEP:  cmd.op = OP_CSTEP;
			S_MUL_X:     cmd.op = OP_MUL_X;
			S_MUL_Y:     cmd.op = OP_MUL_Y;
			S_SUMS:      cmd.op = OP_SUMS;
			S_SQ1:       cmd.op = OP_SQ1;
			S_SQ2:       cmd.op = OP_SQ2;
			S_SQ3:       cmd.op = OP_SQ3;
			S_SQRT:      cmd.op = OP_SQRT;
			S_SQRT_DONE: cmd.op = OP_SQRT_DONE;
			S_VLOAD:     cmd.op = OP_VLOAD;
			S_VSTEP:     cmd.op = OP_CSTEP;
			S_VDONE:     cmd.op = OP_VDONE;
			S_MAX:       cmd.op = OP_MAX;
			S_NORM:      cmd.op = OP_NOP;
			S_DLOAD:     cmd.op = OP_DLOAD;
			S_DSTEP:     cmd.op = OP_DSTEP;
			S_DDONE:     cmd.op = OP_DDONE;
			S_OUT:       if (out_free) cmd.op = OP_OUT;
			default:     cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// The step counter restarts on every state change.
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
			if (state_q == S_SUMS || state_q == S_NORM) begin
				sel_q <= '0;
			end else if (state_q == S_VDONE || state_q == S_DDONE) begin
				sel_q <= sel_q + 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;

`ifndef SYNTH
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output state");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT_STEP || state_q == S_VSTEP) |-> (cnt_q <= ROT_LAST))
		else $error("CORDIC step count overran");
	a_sel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUMS) |=> (sel_q == 2'd0))
		else $error("module select not restarted");
`endif

endmodule

FILE: hdl/swerve_module_kinematics_unit.sv
// ----------------------------------------------------------------------------
// swerve_module_kinematics_unit: four-module swerve drive inverse kinematics
// Rotates the field-oriented strafe command by the yaw and returns each wheel
// module's speed and steering angle.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An item passes through the shared CORDIC
// unit (one micro-rotation per cycle, once for the yaw and once per module),
// the bit-serial square root and, only when a speed above 1.0 calls for
// normalizing, the bit-serial divider. The next item is accepted while a
// finished result still waits on the output.
module swerve_module_kinematics_unit import skm_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// strafe_x[15:0], strafe_y[31:16], turn_rate[47:32], robot_heading[63:48]
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// front_right_speed[14:0], front_left_speed[29:15], rear_right_speed[44:30],
	// rear_left_speed[59:45], front_right_steer[75:60], front_left_steer[91:76],
	// rear_right_steer[107:92], rear_left_steer[123:108], zeros[127:124]
	output logic [127:0] m_axis_tdata
);

	cmd_t               cmd;
	stat_t              stat;
	logic [14:0]        fr_sp, fl_sp, rr_sp, rl_sp;
	logic signed [15:0] fr_st, fl_st, rr_st, rl_st;

	skm_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	skm_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_data           (s_axis_tdata),
		.front_right_speed (fr_sp),
		.front_left_speed  (fl_sp),
		.rear_right_speed  (rr_sp),
		.rear_left_speed   (rl_sp),
		.front_right_steer (fr_st),
		.front_left_steer  (fl_st),
		.rear_right_steer  (rr_st),
		.rear_left_steer   (rl_st)
	);

	assign m_axis_tdata = {4'h0, rl_st, rr_st, fl_st, fr_st, rl_sp, rr_sp, fl_sp, fr_sp};

endmodule

FILE: tb/sv/tb_swerve_module_kinematics_unit.sv
// ----------------------------------------------------------------------------
// tb_swerve_module_kinematics_unit: self-checking bench for the kinematics unit
// Drives drive commands over the input stream and predicts each result
// (four wheel speeds, four steering angles and the held angles) with its own
// fixed-point model of the rotation, square roots, CORDIC vectoring and
// normalizing. Runs directed corners, then random commands under several
// idle and stall mixes, with one long output hold-off and two full drains.
// ----------------------------------------------------------------------------
class wheel_cmd_scoreboard;
	typedef struct {
		logic [3:0][14:0] speed;
		logic [3:0][15:0] steer;
	} wheel_set_t;

	localparam int STEPS = 16;
	wheel_set_t expected_sets[$];
	logic [15:0] held_steer[4];
	int errors;
	int results_seen;
	int zero_cmds;
	int normalized;
	logic [31:0] atan_lut[24];

	function new();
		atan_lut = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
			32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
		foreach (held_steer[i]) held_steer[i] = '0;
		errors = 0;
		results_seen = 0;
		zero_cmds = 0;
		normalized = 0;
	endfunction

	// Field-to-robot rotation by the yaw, scaled by the inverse CORDIC gain.
	function void rotate_by_yaw(longint sx, longint sy, logic [31:0] ang,
			output longint nx, output longint ny);
		longint x, y, z, dx, dy;
		x = sx;
		y = sy;
		if (ang > skm_pkg::QUARTER_TURN && ang < 32'hC000_0000) begin
			x = -x;
			y = -y;
			ang = ang - skm_pkg::HALF_TURN;
		end
		z = longint'($signed(ang));
		x = x * 256;
		y = y * 256;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_lut[i]);
			end else begin
				x += dx; y -= dy; z += longint'(atan_lut[i]);
			end
		end
		nx = (x * 39796 + (64'sd1 <<< 23)) >>> 24;
		ny = (y * 39796 + (64'sd1 <<< 23)) >>> 24;
	endfunction

	function logic [15:0] steer_angle(longint first, longint second);
		longint x, y, dx, dy;
		logic [31:0] z, t;
		logic [15:0] r;
		x = second;
		y = first;
		z = '0;
		if (x == 0 && y == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = skm_pkg::HALF_TURN;
		end
		x = x * 256;
		y = y * 256;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_lut[i];
			end else begin
				x -= dx; y += dy; z -= atan_lut[i];
			end
		end
		t = z + 32'h8000;
		r = t[31:16];
		return 16'd0 - r;
	endfunction

	function longint unsigned wheel_speed(longint a, longint b);
		longint unsigned v, r, bt;
		v = longint'(a * a) + longint'(b * b);
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	function void note_command(logic [63:0] d);
		longint sx, sy, tr, nx, ny, a, b, c, e;
		longint unsigned sp[4], mx;
		logic [31:0] ang;
		wheel_set_t w;
		sx = longint'($signed(d[15:0]));
		sy = longint'($signed(d[31:16]));
		tr = longint'($signed(d[47:32]));
		ang = 32'd0 - {d[63:48], 16'd0};
		rotate_by_yaw(sx, sy, ang, nx, ny);
		a = nx - tr;
		b = nx + tr;
		c = ny - tr;
		e = ny + tr;
		sp[0] = wheel_speed(b, c);
		sp[1] = wheel_speed(b, e);
		sp[2] = wheel_speed(a, c);
		sp[3] = wheel_speed(a, e);
		// A command of all zeros keeps the wheels pointed where they were.
		if (sx != 0 || sy != 0 || tr != 0) begin
			held_steer[0] = steer_angle(b, c);
			held_steer[1] = steer_angle(b, e);
			held_steer[2] = steer_angle(a, c);
			held_steer[3] = steer_angle(a, e);
		end else begin
			zero_cmds++;
		end
		mx = sp[0];
		for (int i = 1; i < 4; i++)
			if (sp[i] > mx) mx = sp[i];
		if (mx > 16384) begin
			normalized++;
			for (int i = 0; i < 4; i++)
				sp[i] = (sp[i] * 16384 + mx / 2) / mx;
		end
		for (int i = 0; i < 4; i++) begin
			w.speed[i] = sp[i][14:0];
			w.steer[i] = held_steer[i];
		end
		expected_sets.push_back(w);
	endfunction

	function void check_result(logic [127:0] d);
		wheel_set_t w;
		string names[4];
		names = '{"front_right", "front_left", "rear_right", "rear_left"};
		results_seen++;
		if (expected_sets.size() == 0) begin
			$error("result transfer with no command outstanding");
			errors++;
			return;
		end
		w = expected_sets.pop_front();
		for (int i = 0; i < 4; i++) begin
			if (d[15*i +: 15] !== w.speed[i]) begin
				$error("%s_speed expected %0d got %0d", names[i], w.speed[i],
					d[15*i +: 15]);
				errors++;
			end
			if (d[60 + 16*i +: 16] !== w.steer[i]) begin
				$error("%s_steer expected %0d got %0d", names[i],
					$signed(w.steer[i]), $signed(d[60 + 16*i +: 16]));
				errors++;
			end
		end
	endfunction
endclass

module tb_swerve_module_kinematics_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam int DRAIN_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int HOLD_CYCLES = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	wheel_cmd_scoreboard sb = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	longint cycles = 0;

	swerve_module_kinematics_unit #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_swerve_module_kinematics_unit failed");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off when requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served < hold_requests) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	task automatic send_cmd(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] tr, input logic [15:0] hd);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hd, tr, sy, sx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command({hd, tr, sy, sx});
	endtask

	function automatic logic [15:0] rand_cmd_field(int kind);
		case ($urandom_range(3))
			0: return (kind < 30) ? 16'(16384) : 16'($urandom_range(65535));
			1: return (kind < 30) ? 16'(-16384) : 16'($urandom_range(65535));
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic send_random_cmd();
		int kind;
		logic [15:0] f[3];
		kind = $urandom_range(99);
		foreach (f[i]) begin
			if (kind < 5)
				f[i] = '0;
			else if (kind < 15 && $urandom_range(2) == 0)
				f[i] = '0;
			else if (kind < 45)
				f[i] = rand_cmd_field(kind);
			else
				f[i] = 16'($signed($urandom_range(32768)) - 16384);
		end
		send_cmd(f[0], f[1], f[2], 16'($urandom_range(65535)));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_sets.size() != 0) @(posedge clk);
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		phase_idle = '{0, 75, 0, 19};
		phase_stall = '{0, 0, 75, 19};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: full-scale commands, every yaw quadrant, zero pairs,
		// a wheel pointing straight back, and zero commands holding the angles.
		send_cmd(16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(16'd0, 16'(-8192), 16'd0, 16'd0);
		send_cmd(16'd0, 16'd0, 16'd0, 16'h4000);
		send_cmd(16'(16384), 16'(16384), 16'(16384), 16'd0);
		send_cmd(16'(-16384), 16'(-16384), 16'(-16384), 16'hFFFF);
		send_cmd(16'(16384), 16'd0, 16'd0, 16'h4000);
		send_cmd(16'd0, 16'(16384), 16'd0, 16'h8000);
		send_cmd(16'(-16384), 16'd0, 16'd0, 16'hC000);
		send_cmd(16'd0, 16'd0, 16'(16384), 16'h2000);
		send_cmd(16'd0, 16'd0, 16'd0, 16'h1234);
		send_cmd(16'd0, 16'd0, 16'(-16384), 16'h4001);
		send_cmd(16'd8192, 16'd0, 16'(-8192), 16'd0);
		send_cmd(16'd0, 16'd8192, 16'd8192, 16'd0);
		send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'hBFFF);
		send_cmd(16'h8000, 16'h7FFF, 16'h8000, 16'h3FFF);
		send_cmd(16'hFFFF, 16'h0001, 16'hFFFF, 16'h8001);
		send_cmd(16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_cmd(16'd100, 16'(-100), 16'd1, 16'h7FFF);

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = phase_idle[p];
			sink_stall_pct = phase_stall[p];
			if (p == 0)
				hold_requests++;
			if (p == 3)
				drain();
			repeat (358) send_random_cmd();
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results: %0d zero commands held their angles, %0d normalized.",
			sb.results_seen, sb.zero_cmds, sb.normalized);
		$display("Phases: free flow, sparse input, heavy output stall, mixed; one long hold-off.");
		if (sb.errors == 0 && sb.expected_sets.size() == 0)
			$display("tb_swerve_module_kinematics_unit passed");
		else
			$display("tb_swerve_module_kinematics_unit failed");
		$finish;
	end
endmodule

FILE: swerve_module_kinematics_unit.f
hdl/skm_pkg.sv
hdl/skm_cordic.sv
hdl/skm_datapath.sv
hdl/skm_ctrl.sv
hdl/swerve_module_kinematics_unit.sv
tb/sv/tb_swerve_module_kinematics_unit.sv
